>>> rtl/faa_pkg.sv
// Package for the fault alarm annunciator: types, codes and reset constants.
package faa_pkg;

    localparam int PEERS_DEFAULT = 16;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_PEER_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_BLINK_INTERVAL = 2'd1;
    localparam logic [1:0] REG_CRITICAL_A = 2'd2;
    localparam logic [1:0] REG_CRITICAL_B = 2'd3;

    localparam logic [15:0] PEER_TIMEOUT_RESET = 16'd10000;
    localparam logic [15:0] BLINK_INTERVAL_RESET = 16'd500;
    localparam logic [3:0] CRITICAL_A_RESET = 4'd1;
    localparam logic [3:0] CRITICAL_B_RESET = 4'd2;

    // event kinds
    localparam logic [2:0] KIND_LOCAL_FAULT = 3'd0;
    localparam logic [2:0] KIND_PEER_ALERT = 3'd1;
    localparam logic [2:0] KIND_PEER_CLEAR = 3'd2;
    localparam logic [2:0] KIND_CLEAR = 3'd3;
    localparam logic [2:0] KIND_TICK = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LOCAL = 2'd1,
        MODE_PEER = 2'd2
    } mode_t;

    // buzzer codes: off, low tone and high tone
    typedef enum logic [1:0] {
        TONE_OFF = 2'd0,
        TONE_LOW = 2'd1,
        TONE_HIGH = 2'd2
    } tone_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] peer_index;
        logic [3:0] fault_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0] mode_out;
        logic [3:0] fault_out;
        logic       red_led;
        logic       green_led;
        logic [1:0] tone;
        logic       any_peer_alerting;
    } out_item_t;

endpackage

>>> rtl/fault_alarm_annunciator.sv
// Fault alarm annunciator top level: event register, state update, result register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------
//  in       | input     | in_valid / in_stall  | in_item  (kind, peer, code)
//  out      | output    | out_valid / out_stall| out_item (mode, leds, tone)
//  cfg      | APB slave | psel/penable/pready  | paddr, pwdata, prdata
//
// One event per clock while the result side is not stalled. An event is captured in the
// input register, and the single state update between the two registers computes its
// result into the output register.
// Reset clears all control state and loads the register defaults.
// A stalled result holds; the input register still takes one more event and
// stalls only when both registers are full.
module fault_alarm_annunciator #(
    parameter int PEERS = faa_pkg::PEERS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  faa_pkg::in_item_t        in_item,
    output logic                     out_valid,
    input  logic                     out_stall,
    output faa_pkg::out_item_t       out_item,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [faa_pkg::ADDR_W-1:0] paddr,
    input  logic [faa_pkg::DATA_W-1:0] pwdata,
    output logic [faa_pkg::DATA_W-1:0] prdata,
    output logic                     pready
);

    // configuration
    logic [15:0] peer_timeout_reg;
    logic [15:0] blink_interval_reg;
    logic [3:0]  critical_a_reg;
    logic [3:0]  critical_b_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    // pipeline
    logic               in_valid_reg;
    faa_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    faa_pkg::out_item_t out_item_reg;
    logic               advance;
    logic               load_in;

    // alarm state
    faa_pkg::mode_t     mode_reg, mode_next;
    logic [3:0]         fault_reg, fault_next;
    logic [PEERS-1:0]   peer_bits_reg, peer_bits_next;
    logic [31:0]        now_reg, now_next;
    logic [31:0]        alert_time_reg, alert_time_next;
    logic [31:0]        toggle_time_reg, toggle_time_next;
    logic               phase_reg, phase_next;
    logic               red_reg, red_next;
    logic               green_reg, green_next;
    faa_pkg::tone_t     tone_reg, tone_next;

    logic               peer_ok;
    logic [PEERS-1:0]   peer_mask;
    logic [31:0]        now_inc;
    logic               timed_out;
    logic               blink_due;
    logic               critical;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_index)
            faa_pkg::REG_PEER_TIMEOUT:   prdata = {16'b0, peer_timeout_reg};
            faa_pkg::REG_BLINK_INTERVAL: prdata = {16'b0, blink_interval_reg};
            faa_pkg::REG_CRITICAL_A:     prdata = {28'b0, critical_a_reg};
            faa_pkg::REG_CRITICAL_B:     prdata = {28'b0, critical_b_reg};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_timeout_reg   <= faa_pkg::PEER_TIMEOUT_RESET;
            blink_interval_reg <= faa_pkg::BLINK_INTERVAL_RESET;
            critical_a_reg     <= faa_pkg::CRITICAL_A_RESET;
            critical_b_reg     <= faa_pkg::CRITICAL_B_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                faa_pkg::REG_PEER_TIMEOUT:   peer_timeout_reg   <= pwdata[15:0];
                faa_pkg::REG_BLINK_INTERVAL: blink_interval_reg <= pwdata[15:0];
                faa_pkg::REG_CRITICAL_A:     critical_a_reg     <= pwdata[3:0];
                faa_pkg::REG_CRITICAL_B:     critical_b_reg     <= pwdata[3:0];
                default:                     ;
            endcase
        end
    end

    // the event in the input register is processed when the result register
    // is free or being emptied this cycle
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign load_in   = !in_valid_reg || advance;
    assign in_stall  = !load_in;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_in)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in && in_valid)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg.mode_out          <= mode_next;
            out_item_reg.fault_out         <= fault_next;
            out_item_reg.red_led           <= red_next;
            out_item_reg.green_led         <= green_next;
            out_item_reg.tone              <= tone_next;
            out_item_reg.any_peer_alerting <= |peer_bits_next;
        end
    end

    assign peer_ok   = 32'(in_item_reg.peer_index) < PEERS;
    assign peer_mask = peer_ok ? (PEERS'(1) << in_item_reg.peer_index) : '0;
    assign now_inc   = now_reg + 32'd1;
    assign timed_out = (now_inc - alert_time_reg) >= {16'b0, peer_timeout_reg};
    assign blink_due = (now_inc - toggle_time_reg) >= {16'b0, blink_interval_reg};
    assign critical  = (in_item_reg.fault_code == critical_a_reg) ||
                       (in_item_reg.fault_code == critical_b_reg);

    always_comb
    begin
        logic go_idle;
        go_idle          = 1'b0;
        mode_next        = mode_reg;
        fault_next       = fault_reg;
        peer_bits_next   = peer_bits_reg;
        now_next         = now_reg;
        alert_time_next  = alert_time_reg;
        toggle_time_next = toggle_time_reg;
        phase_next       = phase_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        tone_next        = tone_reg;

        case (in_item_reg.kind)
            faa_pkg::KIND_LOCAL_FAULT:
            begin
                fault_next = in_item_reg.fault_code;
                mode_next  = faa_pkg::MODE_LOCAL;
                green_next = 1'b0;
                tone_next  = critical ? faa_pkg::TONE_HIGH : faa_pkg::TONE_LOW;
            end
            faa_pkg::KIND_PEER_ALERT:
            begin
                peer_bits_next = peer_bits_reg | peer_mask;
                if (mode_reg != faa_pkg::MODE_LOCAL)
                begin
                    alert_time_next = now_reg;
                    fault_next      = in_item_reg.fault_code;
                    if (mode_reg != faa_pkg::MODE_PEER)
                    begin
                        mode_next  = faa_pkg::MODE_PEER;
                        green_next = 1'b0;
                        tone_next  = faa_pkg::TONE_LOW;
                    end
                end
            end
            faa_pkg::KIND_PEER_CLEAR:
            begin
                peer_bits_next = peer_bits_reg & ~peer_mask;
                go_idle = (mode_reg == faa_pkg::MODE_PEER) && (peer_bits_next == '0);
            end
            faa_pkg::KIND_CLEAR:
            begin
                go_idle = 1'b1;
            end
            faa_pkg::KIND_TICK:
            begin
                now_next = now_inc;
                if (mode_reg != faa_pkg::MODE_IDLE)
                begin
                    if (mode_reg == faa_pkg::MODE_PEER && timed_out)
                    begin
                        go_idle = 1'b1;
                    end
                    else if (blink_due)
                    begin
                        toggle_time_next = now_inc;
                        phase_next       = !phase_reg;
                        red_next         = !phase_reg;
                    end
                end
            end
            default:
            begin
                // unknown event: state unchanged, current outputs reported
            end
        endcase

        if (go_idle)
        begin
            peer_bits_next = '0;
            mode_next      = faa_pkg::MODE_IDLE;
            fault_next     = 4'd0;
            tone_next      = faa_pkg::TONE_OFF;
            red_next       = 1'b0;
            green_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= faa_pkg::MODE_IDLE;
            fault_reg       <= 4'd0;
            peer_bits_reg   <= '0;
            now_reg         <= 32'd0;
            alert_time_reg  <= 32'd0;
            toggle_time_reg <= 32'd0;
            phase_reg       <= 1'b0;
            red_reg         <= 1'b0;
            green_reg       <= 1'b1;
            tone_reg        <= faa_pkg::TONE_OFF;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            fault_reg       <= fault_next;
            peer_bits_reg   <= peer_bits_next;
            now_reg         <= now_next;
            alert_time_reg  <= alert_time_next;
            toggle_time_reg <= toggle_time_next;
            phase_reg       <= phase_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            tone_reg        <= tone_next;
        end
    end

endmodule

>>> rtl/faa_checker.sv
// Port-level checker for the fault alarm annunciator, bound to the top level.
module faa_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_stall,
    input faa_pkg::out_item_t       out_item
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // idle shows green only, no tone and no fault code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.mode_out == faa_pkg::MODE_IDLE |->
            out_item.green_led && !out_item.red_led &&
            out_item.tone == faa_pkg::TONE_OFF && out_item.fault_out == 4'd0)
        else $error("idle result with alarm outputs");

    // any alarm mode drops green and sounds the buzzer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.mode_out != faa_pkg::MODE_IDLE |->
            !out_item.green_led && out_item.tone != faa_pkg::TONE_OFF)
        else $error("alarm result without buzzer or with green lit");

endmodule

bind fault_alarm_annunciator faa_checker u_faa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

>>> tb/sv/tb_fault_alarm_annunciator.sv
// Self-checking testbench for the fault alarm annunciator: event stimulus, APB setup, scoreboard.
module tb_fault_alarm_annunciator;

    localparam int RUN_LIMIT_CYCLES = 400000;
    localparam int DRAIN_LIMIT_CYCLES = 5000;
    localparam int DRAIN_SLACK_CYCLES = 4;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int RANDOM_PHASES = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PRINT_CAP = 100;

    // event kinds the block does not decode
    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    // Tracks the annunciator state and holds the results it should produce.
    class annunciator_scoreboard;
        logic [15:0]        timeout_ms;
        logic [15:0]        blink_ms;
        logic [3:0]         crit_a;
        logic [3:0]         crit_b;
        faa_pkg::mode_t     mode;
        logic [3:0]         fault;
        logic [15:0]        peers;
        logic [31:0]        now_ms;
        logic [31:0]        alert_ms;
        logic [31:0]        toggle_ms;
        logic               phase;
        logic               red;
        logic               green;
        faa_pkg::tone_t     tone;
        faa_pkg::out_item_t expected_q[$];
        int                 errors;
        int                 checked;

        function new();
            timeout_ms = faa_pkg::PEER_TIMEOUT_RESET;
            blink_ms = faa_pkg::BLINK_INTERVAL_RESET;
            crit_a = faa_pkg::CRITICAL_A_RESET;
            crit_b = faa_pkg::CRITICAL_B_RESET;
            mode = faa_pkg::MODE_IDLE;
            fault = '0;
            peers = '0;
            now_ms = '0;
            alert_ms = '0;
            toggle_ms = '0;
            phase = 1'b0;
            red = 1'b0;
            green = 1'b1;
            tone = faa_pkg::TONE_OFF;
            errors = 0;
            checked = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                faa_pkg::REG_PEER_TIMEOUT:   timeout_ms = value[15:0];
                faa_pkg::REG_BLINK_INTERVAL: blink_ms = value[15:0];
                faa_pkg::REG_CRITICAL_A:     crit_a = value[3:0];
                faa_pkg::REG_CRITICAL_B:     crit_b = value[3:0];
                default: ;
            endcase
        endfunction

        function void go_idle();
            peers = '0;
            mode = faa_pkg::MODE_IDLE;
            fault = '0;
            tone = faa_pkg::TONE_OFF;
            red = 1'b0;
            green = 1'b1;
        endfunction

        function void note_event(faa_pkg::in_item_t ev);
            faa_pkg::out_item_t res;
            logic [31:0]        since;
            case (ev.kind)
                faa_pkg::KIND_LOCAL_FAULT:
                begin
                    fault = ev.fault_code;
                    mode = faa_pkg::MODE_LOCAL;
                    green = 1'b0;
                    if (ev.fault_code == crit_a || ev.fault_code == crit_b)
                        tone = faa_pkg::TONE_HIGH;
                    else
                        tone = faa_pkg::TONE_LOW;
                end
                faa_pkg::KIND_PEER_ALERT:
                begin
                    peers[ev.peer_index] = 1'b1;
                    // a local fault masks peer alarms, only the bitmap moves
                    if (mode != faa_pkg::MODE_LOCAL)
                    begin
                        alert_ms = now_ms;
                        fault = ev.fault_code;
                        if (mode != faa_pkg::MODE_PEER)
                        begin
                            mode = faa_pkg::MODE_PEER;
                            green = 1'b0;
                            tone = faa_pkg::TONE_LOW;
                        end
                    end
                end
                faa_pkg::KIND_PEER_CLEAR:
                begin
                    peers[ev.peer_index] = 1'b0;
                    if (mode == faa_pkg::MODE_PEER && peers == '0)
                        go_idle();
                end
                faa_pkg::KIND_CLEAR:
                    go_idle();
                faa_pkg::KIND_TICK:
                begin
                    now_ms = now_ms + 32'd1;
                    if (mode != faa_pkg::MODE_IDLE)
                    begin
                        since = now_ms - alert_ms;
                        if (mode == faa_pkg::MODE_PEER && since >= {16'd0, timeout_ms})
                            go_idle();
                        else
                        begin
                            since = now_ms - toggle_ms;
                            if (since >= {16'd0, blink_ms})
                            begin
                                toggle_ms = now_ms;
                                phase = ~phase;
                                red = phase;
                            end
                        end
                    end
                end
                default: ;
            endcase
            res.mode_out = mode;
            res.fault_out = fault;
            res.red_led = red;
            res.green_led = green;
            res.tone = tone;
            res.any_peer_alerting = |peers;
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            if (errors < PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(faa_pkg::out_item_t got);
            faa_pkg::out_item_t want;
            string              bad;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            bad = "";
            if (got.mode_out !== want.mode_out) bad = {bad, " mode_out"};
            if (got.fault_out !== want.fault_out) bad = {bad, " fault_out"};
            if (got.red_led !== want.red_led) bad = {bad, " red_led"};
            if (got.green_led !== want.green_led) bad = {bad, " green_led"};
            if (got.tone !== want.tone) bad = {bad, " tone"};
            if (got.any_peer_alerting !== want.any_peer_alerting)
                bad = {bad, " any_peer_alerting"};
            if (bad != "")
                report_mismatch($sformatf("result %0d:%s got %h want %h",
                                          checked, bad, got, want));
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    faa_pkg::in_item_t            in_item;
    logic                         out_valid;
    logic                         out_stall;
    faa_pkg::out_item_t           out_item;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [faa_pkg::ADDR_W-1:0]   paddr;
    logic [faa_pkg::DATA_W-1:0]   pwdata;
    logic [faa_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    annunciator_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int recv_burst = 0;
    int events_sent = 0;
    int settings_used = 0;

    fault_alarm_annunciator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_CYCLES * 8);
        $display("tb_fault_alarm_annunciator: FAIL");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off in one phase of the run
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (recv_burst > 0)
            begin
                out_stall = 1'b1;
                recv_burst--;
            end
            else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                out_stall = 1'b1;
                recv_burst = $urandom_range(1, 6) - 1;
            end
            else
                out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    // entered and left at a falling edge
    task send_event(input faa_pkg::in_item_t ev);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = ev;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_event(ev);
        events_sent++;
        @(negedge clk);
    endtask

    task send_fields(input logic [2:0] kind, input logic [3:0] peer, input logic [3:0] code);
        faa_pkg::in_item_t ev;
        ev.kind = kind;
        ev.peer_index = peer;
        ev.fault_code = code;
        send_event(ev);
    endtask

    task wait_drained();
        int waited;
        waited = 0;
        in_valid = 1'b0;
        while (sb.expected_q.size() > 0 && waited < DRAIN_LIMIT_CYCLES)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_SLACK_CYCLES) @(negedge clk);
    endtask

    // write, then read back; entered and left at a falling edge
    task write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        case (idx)
            faa_pkg::REG_CRITICAL_A, faa_pkg::REG_CRITICAL_B: mask = 32'h0000_000F;
            default:                                          mask = 32'h0000_FFFF;
        endcase
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== (value & mask))
            sb.report_mismatch($sformatf("register %0d read %h, wrote %h", idx, prdata, value));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task apply_setting(input logic [15:0] timeout, input logic [15:0] blink,
                       input logic [3:0] code_a, input logic [3:0] code_b);
        write_register(faa_pkg::REG_PEER_TIMEOUT, {16'd0, timeout});
        write_register(faa_pkg::REG_BLINK_INTERVAL, {16'd0, blink});
        write_register(faa_pkg::REG_CRITICAL_A, {28'd0, code_a});
        write_register(faa_pkg::REG_CRITICAL_B, {28'd0, code_b});
        settings_used++;
    endtask

    // mostly ticks and alerts on a few peers so alarms build up, expire and clear
    function automatic faa_pkg::in_item_t random_event();
        faa_pkg::in_item_t ev;
        int                pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            ev.peer_index = 4'($urandom_range(0, 15));
        else
            ev.peer_index = 4'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       ev.fault_code = sb.crit_a;
            1:       ev.fault_code = sb.crit_b;
            default: ev.fault_code = 4'($urandom_range(0, 15));
        endcase
        if (pick < 45)
            ev.kind = faa_pkg::KIND_TICK;
        else if (pick < 65)
            ev.kind = faa_pkg::KIND_PEER_ALERT;
        else if (pick < 80)
            ev.kind = faa_pkg::KIND_PEER_CLEAR;
        else if (pick < 88)
            ev.kind = faa_pkg::KIND_LOCAL_FAULT;
        else if (pick < 95)
            ev.kind = faa_pkg::KIND_CLEAR;
        else
        begin
            case ($urandom_range(0, 2))
                0:       ev.kind = KIND_SPARE_5;
                1:       ev.kind = KIND_SPARE_6;
                default: ev.kind = KIND_SPARE_7;
            endcase
        end
        return ev;
    endfunction

    initial
    begin
        int idle_levels[4];
        idle_levels = '{0, 10, 25, 40};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: tones, local priority, peer bitmap, undecoded kinds
        send_fields(KIND_SPARE_7, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_LOCAL_FAULT, 4'd15, 4'd1);
        send_fields(faa_pkg::KIND_LOCAL_FAULT, 4'd0, 4'd2);
        send_fields(faa_pkg::KIND_LOCAL_FAULT, 4'd0, 4'd15);
        send_fields(faa_pkg::KIND_LOCAL_FAULT, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_PEER_ALERT, 4'd15, 4'd9);
        send_fields(faa_pkg::KIND_TICK, 4'd0, 4'd0);
        send_fields(KIND_SPARE_5, 4'd15, 4'd15);
        send_fields(faa_pkg::KIND_PEER_CLEAR, 4'd15, 4'd0);
        send_fields(faa_pkg::KIND_CLEAR, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_PEER_ALERT, 4'd0, 4'd15);
        send_fields(faa_pkg::KIND_PEER_ALERT, 4'd15, 4'd0);
        send_fields(faa_pkg::KIND_TICK, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_PEER_CLEAR, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_PEER_CLEAR, 4'd15, 4'd0);
        send_fields(faa_pkg::KIND_TICK, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_PEER_ALERT, 4'd7, 4'd3);
        send_fields(faa_pkg::KIND_LOCAL_FAULT, 4'd7, 4'd1);
        send_fields(faa_pkg::KIND_CLEAR, 4'd0, 4'd0);
        send_fields(KIND_SPARE_6, 4'd7, 4'd7);

        // zero timeout and interval: expire and toggle on the next tick
        wait_drained();
        apply_setting(16'd0, 16'd0, 4'd0, 4'd15);
        send_fields(faa_pkg::KIND_LOCAL_FAULT, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_TICK, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_TICK, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_CLEAR, 4'd0, 4'd0);
        send_fields(faa_pkg::KIND_PEER_ALERT, 4'd3, 4'd4);
        send_fields(faa_pkg::KIND_TICK, 4'd3, 4'd4);
        send_fields(faa_pkg::KIND_PEER_ALERT, 4'd3, 4'd4);
        send_fields(faa_pkg::KIND_PEER_CLEAR, 4'd3, 4'd4);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: apply_setting(16'd1, 16'd1, 4'd15, 4'd1);
                1: apply_setting(16'hFFFF, 16'hFFFF, 4'd15, 4'd15);
                default: apply_setting(16'($urandom_range(1, 40)), 16'($urandom_range(1, 12)),
                                       4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
            endcase
            if (ph == RANDOM_PHASES - 1)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = idle_levels[$urandom_range(0, 3)];
                recv_idle_pct = idle_levels[$urandom_range(0, 3)];
            end
            // block fills up and backs up its input while results are held
            if (ph == 4)
                hold_left = LONG_HOLD_CYCLES;
            repeat (ITEMS_PER_PHASE) send_event(random_event());
        end

        wait_drained();
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.expected_q.size()));
        $display("covered %0d events over %0d register settings, %0d results checked",
                 events_sent, settings_used, sb.checked);
        $display("included idle, local and peer modes, expiry, blinking and stalls");
        if (sb.errors == 0)
            $display("tb_fault_alarm_annunciator: PASS");
        else
            $display("tb_fault_alarm_annunciator: FAIL");
        $finish;
    end

endmodule
